[design/spwm_pkg.sv]
`timescale 1ns / 1ps

package spwm_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [CfgIdxW-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FULL_SCALE = 2'd1;

  localparam int unsigned StepW  = 32;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned MagW   = 15;

  localparam logic [StepW-1:0]  PHASE_STEP_RST = 32'd42949673;
  localparam logic [ScaleW-1:0] FULL_SCALE_RST = 16'd19999;

  localparam logic [15:0] SINE_OFFSET = 16'd32768;

  // (pi/2)^n / n! in Q2.30
  localparam logic [63:0] SC1 = 64'd1686629713;
  localparam logic [63:0] SC3 = 64'd693598668;
  localparam logic [63:0] SC5 = 64'd85569306;
  localparam logic [63:0] SC7 = 64'd5026995;
  localparam logic [63:0] SC9 = 64'd172273;

  // sine magnitude after table read, with the half-wave sign
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } sine_mag_t;

  // Q0.15 sin(pi/2 * k / 2^addr_bits), evaluated at elaboration only
  function automatic logic [MagW-1:0] quarter_sine(input logic [63:0] k,
                                                   input int unsigned addr_bits);
    logic [63:0] kk;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] r;
    kk = k;
    if (kk > (64'd1 << addr_bits)) begin
      kk = 64'd1 << addr_bits;
    end
    u  = (kk << 30) >> addr_bits;
    u2 = (u * u) >> 30;
    p  = SC9;
    p  = SC7 - ((u2 * p) >> 30);
    p  = SC5 - ((u2 * p) >> 30);
    p  = SC3 - ((u2 * p) >> 30);
    p  = SC1 - ((u2 * p) >> 30);
    r  = (u * p) >> 30;
    r  = (r + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[MagW-1:0];
  endfunction

endpackage

[design/spwm_phase.sv]
`timescale 1ns / 1ps

module spwm_phase
  import spwm_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       tick_i,
  input  logic [StepW-1:0]           phase_step_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [1:0]                 quad_o,
  output logic [TABLE_ADDR_BITS-1:0] idx_o
);

  localparam int unsigned SumW = (PHASE_BITS > StepW) ? PHASE_BITS : StepW;

  logic [PHASE_BITS-1:0]      phase_acc_q, phase_acc_d;
  logic [SumW-1:0]            sum;
  logic                       valid_q;
  logic [1:0]                 quad_q;
  logic [TABLE_ADDR_BITS-1:0] idx_q;
  logic                       accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // wraps modulo 2^PHASE_BITS
  assign sum = SumW'(phase_acc_q) + SumW'(phase_step_i);

  always_comb begin
    phase_acc_d = phase_acc_q;
    if (accept && tick_i) begin
      phase_acc_d = sum[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      phase_acc_q <= phase_acc_d;
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      quad_q <= phase_acc_d[PHASE_BITS-1 -: 2];
      idx_q  <= phase_acc_d[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    end
  end

  assign valid_o = valid_q;
  assign quad_o  = quad_q;
  assign idx_o   = idx_q;

  a_hold_no_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !tick_i) |=> (phase_acc_q == $past(phase_acc_q)))
    else $error("phase moved on a non-tick word");

  a_adv_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tick_i) |=> (phase_acc_q == $past(sum[PHASE_BITS-1:0])))
    else $error("phase did not advance by the step");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> (phase_acc_q == $past(phase_acc_q)))
    else $error("phase changed without an accepted word");

endmodule

[design/spwm_rom.sv]
`timescale 1ns / 1ps

module spwm_rom
  import spwm_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [1:0]                 quad_i,
  input  logic [TABLE_ADDR_BITS-1:0] idx_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output sine_mag_t                  sine_o
);

  localparam int unsigned QtrN = 1 << TABLE_ADDR_BITS;
  localparam int unsigned KW   = TABLE_ADDR_BITS + 1;

  logic [MagW-1:0] qtr_rom [QtrN+1];
  logic [KW-1:0]   addr;
  logic            valid_q;
  sine_mag_t       sine_q;

  for (genvar k = 0; k <= QtrN; k++) begin : g_rom
    assign qtr_rom[k] = quarter_sine(64'(k), TABLE_ADDR_BITS);
  end

  // odd quadrants run the quarter wave backwards
  assign addr = quad_i[0] ? (KW'(QtrN) - {1'b0, idx_i}) : {1'b0, idx_i};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sine_q.neg <= quad_i[1];
      sine_q.mag <= qtr_rom[addr];
    end
  end

  assign valid_o = valid_q;
  assign sine_o  = sine_q;

endmodule

[design/spwm_scale.sv]
`timescale 1ns / 1ps

module spwm_scale
  import spwm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sine_mag_t         sine_i,
  input  logic [ScaleW-1:0] full_scale_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DutyW-1:0]  duty_o
);

  logic [15:0]              offset;
  logic [ScaleW+16-1:0]     prod;
  logic                     valid_q;
  logic [DutyW-1:0]         duty_q;

  // sine + 32768 lies in 1..65535
  assign offset = sine_i.neg ? (SINE_OFFSET - 16'(sine_i.mag))
                             : (SINE_OFFSET + 16'(sine_i.mag));
  assign prod   = (ScaleW+16)'(full_scale_i) * (ScaleW+16)'(offset);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      duty_q <= prod[ScaleW+16-1 -: DutyW];
    end
  end

  assign valid_o = valid_q;
  assign duty_o  = duty_q;

endmodule

[design/sine_pwm_duty_generator.sv]
`timescale 1ns / 1ps
// Sine PWM duty generator: phase accumulator plus quarter-wave sine table.
// Input channel (in_valid_i/in_ready_o, tick_i): each word produces exactly
// one duty word. tick_i = 1 advances the phase by phase_step first; tick_i = 0
// recomputes the duty at the current phase.
// Output channel (out_valid_o/out_ready_i, duty_o): duty =
// (full_scale * (sine + 32768)) >> 16, in 0..full_scale-1 (0 if it is 0).
// Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 phase_step,
// 1 full_scale); other indexes are ignored. Write only while idle.
// Path: each word passes the phase register, the registered table read and
// the multiply into the output register, in that order.
// Throughput: one word per cycle while out_ready_i is high; each stage holds
// one word and moves when the stage after it is empty or draining.
// Stall: while out_ready_i is low the three stages fill; in_ready_o drops
// only once all three hold a word. Nothing is dropped.
// Reset: phase clears to zero, phase_step and full_scale return to their
// defaults (100 Hz at 10 kHz ticks, period count 19999), pipeline empties.

module sine_pwm_duty_generator
  import spwm_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                tick_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DutyW-1:0]    duty_o
);

  logic [StepW-1:0]           phase_step_q;
  logic [ScaleW-1:0]          full_scale_q;
  logic                       ph_valid, ph_ready;
  logic [1:0]                 ph_quad;
  logic [TABLE_ADDR_BITS-1:0] ph_idx;
  logic                       rom_valid, rom_ready;
  sine_mag_t                  rom_sine;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      full_scale_q <= FULL_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PHASE_STEP: phase_step_q <= cfg_wdata_i[StepW-1:0];
        REG_FULL_SCALE: full_scale_q <= cfg_wdata_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  spwm_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .tick_i       (tick_i),
    .phase_step_i (phase_step_q),
    .valid_o      (ph_valid),
    .ready_i      (ph_ready),
    .quad_o       (ph_quad),
    .idx_o        (ph_idx)
  );

  spwm_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .ready_o (ph_ready),
    .quad_i  (ph_quad),
    .idx_i   (ph_idx),
    .valid_o (rom_valid),
    .ready_i (rom_ready),
    .sine_o  (rom_sine)
  );

  spwm_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (rom_valid),
    .ready_o      (rom_ready),
    .sine_i       (rom_sine),
    .full_scale_i (full_scale_q),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .duty_o       (duty_o)
  );

  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && ph_valid && rom_valid))
    else $error("input stalled with room in the pipeline");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && !ph_valid && !rom_valid && out_valid_o && out_ready_i)
      |=> !out_valid_o)
    else $error("duty word invented on an empty pipeline");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> ($stable(phase_step_q) && $stable(full_scale_q)))
    else $error("config changed without a write");

endmodule

[test/sine_duty_checker.sv]
`timescale 1ns / 1ps

module sine_duty_checker
  import spwm_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                tick_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [DutyW-1:0]    duty_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam int unsigned QtrN = 1 << TABLE_ADDR_BITS;
  // Horner terms after the ninth-order one, highest order first from index 3
  localparam logic [3:0][63:0] TAYLOR_TAIL = {SC7, SC5, SC3, SC1};

  logic [MagW-1:0]       quarter_wave [0:QtrN];
  logic [PHASE_BITS-1:0] phase;
  logic [StepW-1:0]      step_cfg;
  logic [ScaleW-1:0]     scale_cfg;
  logic [DutyW-1:0]      duty_expected_q [$];
  logic [DutyW-1:0]      duty_want;
  int                    fail_count = 0;

  assign errors_o = fail_count;

  // Q0.15 sin(pi/2 * k / N), integer series evaluation
  function automatic logic [MagW-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] r;
    int          j;
    x   = (64'(k) << 30) >> TABLE_ADDR_BITS;
    x2  = (x * x) >> 30;
    acc = SC9;
    for (j = 3; j >= 0; j--) begin
      acc = TAYLOR_TAIL[j] - ((x2 * acc) >> 30);
    end
    r = (((x * acc) >> 30) + 64'd16384) >> 15;
    return (r > 64'd32767) ? 15'h7fff : r[MagW-1:0];
  endfunction

  function automatic logic [DutyW-1:0] predict_duty(input logic [PHASE_BITS-1:0] ph,
                                                    input logic [ScaleW-1:0] scale);
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [MagW-1:0]            mag;
    logic [15:0]                level;
    logic [31:0]                prod;
    quad  = ph[PHASE_BITS-1 -: 2];
    idx   = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    // odd quadrants read the table mirrored, the lower half-wave is negated
    mag   = quad[0] ? quarter_wave[QtrN - idx] : quarter_wave[idx];
    level = quad[1] ? SINE_OFFSET - mag : SINE_OFFSET + mag;
    prod  = scale * level;
    return prod[31:16];
  endfunction

  initial begin
    for (int k = 0; k <= QtrN; k++) begin
      quarter_wave[k] = sine_entry(k);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase     = '0;
      step_cfg  = PHASE_STEP_RST;
      scale_cfg = FULL_SCALE_RST;
      duty_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PHASE_STEP: step_cfg = cfg_wdata_i[StepW-1:0];
          REG_FULL_SCALE: scale_cfg = cfg_wdata_i[ScaleW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (tick_i) begin
          phase = phase + step_cfg;
        end
        duty_expected_q.push_back(predict_duty(phase, scale_cfg));
      end
      if (out_valid_i && out_ready_i) begin
        if (duty_expected_q.size() == 0) begin
          fail_count++;
          $error("duty: no word expected, got %0d", duty_i);
        end else begin
          duty_want = duty_expected_q.pop_front();
          if (duty_i !== duty_want) begin
            fail_count++;
            $error("duty: expected %0d, got %0d", duty_want, duty_i);
          end
        end
      end
      pending_o <= duty_expected_q.size();
    end
  end

endmodule

[test/sine_pwm_duty_generator_test.sv]
`timescale 1ns / 1ps

module sine_pwm_duty_generator_test;
  import spwm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                tick;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DutyW-1:0]    duty;
  int                  pending;
  int                  errors;
  int                  gap_pct = 30;
  int                  stall_pct = 30;
  int                  cycles = 0;

  sine_pwm_duty_generator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .tick_i      (tick),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .duty_o      (duty)
  );

  sine_duty_checker duty_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .tick_i      (tick),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .duty_i      (duty),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(input logic t);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every duty word in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_ticks(input int n, input int tick_pct);
    for (int i = 0; i < n; i++) begin
      send_word($urandom_range(99) < tick_pct);
    end
  endtask

  initial begin
    logic [StepW-1:0]  step_val;
    logic [ScaleW-1:0] scale_val;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    tick      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: mid-scale at phase zero, then small steps
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
    drain();

    // quarter-cycle steps hit zero crossings, crest, trough and the wrap
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_FULL_SCALE, 32'h0000_ffff);
    send_word(1'b0);
    repeat (5) send_word(1'b1);
    drain();

    // upper data bits are dropped, so this is a zero scale
    write_reg(REG_FULL_SCALE, 32'hffff_0000);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);
    drain();

    write_reg(REG_PHASE_STEP, 32'hffff_ffff);
    write_reg(REG_FULL_SCALE, 32'd1);
    repeat (3) send_word(1'b1);
    drain();

    // spare indexes leave both registers alone
    write_reg(REG_SPARE_2, $urandom);
    write_reg(REG_SPARE_3, 32'hffff_ffff);
    repeat (3) send_word(1'b1);

    for (int p = 0; p < 8; p++) begin
      drain();
      case ($urandom_range(3))
        0: step_val = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
        1: step_val = $urandom_range(32'h00ff_ffff);
        default: step_val = $urandom;
      endcase
      if (p == 0) begin
        step_val = '0;
      end
      case ($urandom_range(3))
        0: scale_val = 16'hffff;
        1: scale_val = '0;
        default: scale_val = 16'($urandom);
      endcase
      if ($urandom_range(1)) begin
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
      end
      write_reg(REG_PHASE_STEP, step_val);
      write_reg(REG_FULL_SCALE, {16'($urandom), scale_val});
      // one phase runs back to back on both sides
      gap_pct   = (p == 3) ? 0 : 30;
      stall_pct = (p == 3) ? 0 : 30;
      run_ticks(125, 85);
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
